/* hw/rtl/skts_pkg.sv */
// Package for the sorted key table: sizes, operation and status codes.
`default_nettype none
package skts_pkg;
    localparam int Depth    = 64;
    localparam int KeyBytes = 8;
    localparam int AddrW    = $clog2(Depth);
    localparam int CountW   = $clog2(Depth + 1);
    localparam int KeyW     = 64;
    localparam int TagW     = 16;

    localparam logic [KeyW-1:0] KeyMask = {KeyW{1'b1}} << ((8 - KeyBytes) * 8);

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_DELETE = 3'd1,
        OP_SORT   = 3'd2,
        OP_BSRCH  = 3'd3,
        OP_LSRCH  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;
endpackage
`default_nettype wire

/* hw/rtl/sorted_key_table_search.sv */
// Top level of the sorted key table: memory-based sort, search, insert and delete.
//
//  channel | direction | tdata fields (low bit first)         | tuser
//  s_      | in        | op[2:0] key[66:3] tag_in[82:67]      | -
//  m_      | out       | status found_index tag_out entry_cnt | -
//
// Insert and unknown ops go from S_DISPATCH straight to S_DONE for the result word.
// Linear search reads and compares each entry visited (S_SRCH_RD, S_SRCH_CMP); delete then
// reads and writes each entry shifted down (S_DEL_RD, S_DEL_WR). The sort is an insertion
// sort over the key/tag memories: load, hold, read and compare per entry moved past, put.
// Binary search runs the sort, then reads and compares one entry per probe, at most 7 probes.
// Reset clears the state and the count only; the memories are not cleared. s_tready stays low from
// the accepted word until its result word is taken, and a stalled result holds.
`default_nettype none
module sorted_key_table_search
    import skts_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [87:0] s_tdata,   // op[2:0], key[66:3], tag_in[82:67]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // status[1:0], found_index[7:2], tag_out[23:8], entry_count[30:24]
    output logic [31:0]      m_tdata
);
    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_SORT_LD, S_SORT_HOLD, S_SORT_RD, S_SORT_CMP, S_SORT_PUT,
        S_SRCH_RD, S_SRCH_CMP, S_DEL_RD, S_DEL_WR, S_DONE
    } state_t;

    state_t               state_reg;
    logic [2:0]           op_reg;
    logic [KeyW-1:0]      key_reg;
    logic [TagW-1:0]      tag_reg;
    logic [CountW-1:0]    count_reg;
    logic [CountW-1:0]    i_reg;    // outer sort index / search index
    logic [CountW-1:0]    j_reg;    // insertion position
    logic signed [CountW:0] lo_reg, hi_reg;
    logic [KeyW-1:0]      hold_key_reg;
    logic [TagW-1:0]      hold_tag_reg;
    logic [1:0]           st_reg;
    logic [AddrW-1:0]     fidx_reg;
    logic [TagW-1:0]      otag_reg;

    // memories
    logic [KeyW-1:0] key_mem [Depth];
    logic [TagW-1:0] tag_mem [Depth];
    logic [KeyW-1:0] rd_key_reg;
    logic [TagW-1:0] rd_tag_reg;
    logic            we;
    logic [AddrW-1:0] waddr, raddr;
    logic [KeyW-1:0] wkey;
    logic [TagW-1:0] wtag;

    always_ff @(posedge aclk) begin
        if (we) begin
            key_mem[waddr] <= wkey;
            tag_mem[waddr] <= wtag;
        end
        rd_key_reg <= key_mem[raddr];
        rd_tag_reg <= tag_mem[raddr];
    end

    logic signed [CountW:0] mid;
    assign mid = (lo_reg + hi_reg) >>> 1;

    // drive memory ports from the state
    always_comb begin
        we = 1'b0; waddr = '0; wkey = hold_key_reg; wtag = hold_tag_reg; raddr = '0;
        unique case (state_reg)
            S_DISPATCH: begin
                if (op_reg == OP_INSERT && count_reg < CountW'(Depth)) begin
                    we = 1'b1; waddr = count_reg[AddrW-1:0]; wkey = key_reg; wtag = tag_reg;
                end
            end
            S_SORT_LD: raddr = i_reg[AddrW-1:0];
            S_SORT_RD: raddr = AddrW'(j_reg - CountW'(1));
            S_SORT_CMP: begin
                if (rd_key_reg > hold_key_reg) begin
                    we = 1'b1; waddr = j_reg[AddrW-1:0]; wkey = rd_key_reg; wtag = rd_tag_reg;
                end
            end
            S_SORT_PUT: begin
                we = 1'b1; waddr = j_reg[AddrW-1:0];
            end
            S_SRCH_RD: raddr = (op_reg == OP_BSRCH) ? mid[AddrW-1:0] : i_reg[AddrW-1:0];
            S_DEL_RD:  raddr = AddrW'(i_reg + CountW'(1));
            S_DEL_WR: begin
                we = 1'b1; waddr = i_reg[AddrW-1:0]; wkey = rd_key_reg; wtag = rd_tag_reg;
            end
            default: ;
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_DONE);
    assign m_tdata  = {1'b0, 7'(count_reg), otag_reg, 6'(fidx_reg), st_reg};

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: if (s_tvalid) begin
                    op_reg   <= s_tdata[2:0];
                    key_reg  <= s_tdata[66:3] & KeyMask;
                    tag_reg  <= s_tdata[82:67];
                    st_reg   <= ST_OK;
                    fidx_reg <= '0;
                    otag_reg <= '0;
                    state_reg <= S_DISPATCH;
                end
                S_DISPATCH: begin
                    i_reg  <= '0;
                    lo_reg <= '0;
                    hi_reg <= $signed({1'b0, count_reg}) - 8'sd1;
                    if (op_reg == OP_INSERT) begin
                        if (count_reg < CountW'(Depth)) count_reg <= count_reg + CountW'(1);
                        else st_reg <= ST_FULL;
                        state_reg <= S_DONE;
                    end else if (op_reg > OP_LSRCH) begin
                        state_reg <= S_DONE;
                    end else if (count_reg == '0) begin
                        st_reg <= ST_EMPTY;
                        state_reg <= S_DONE;
                    end else if (op_reg == OP_SORT || op_reg == OP_BSRCH) begin
                        // start the insertion sort at element 1
                        i_reg <= CountW'(1);
                        if (count_reg > CountW'(1)) state_reg <= S_SORT_LD;
                        else if (op_reg == OP_SORT) state_reg <= S_DONE;
                        else state_reg <= S_SRCH_RD;
                    end else begin
                        state_reg <= S_SRCH_RD;
                    end
                end
                S_SORT_LD: state_reg <= S_SORT_HOLD;
                // latch element i as the held item
                S_SORT_HOLD: begin
                    hold_key_reg <= rd_key_reg;
                    hold_tag_reg <= rd_tag_reg;
                    j_reg <= i_reg;
                    state_reg <= S_SORT_RD;
                end
                S_SORT_RD: state_reg <= S_SORT_CMP;
                // move a larger entry up one place, else drop the held item here
                S_SORT_CMP: begin
                    if (rd_key_reg > hold_key_reg) begin
                        j_reg <= j_reg - CountW'(1);
                        state_reg <= (j_reg == CountW'(1)) ? S_SORT_PUT : S_SORT_RD;
                    end else begin
                        state_reg <= S_SORT_PUT;
                    end
                end
                S_SORT_PUT: begin
                    if (i_reg + CountW'(1) < count_reg) begin
                        i_reg <= i_reg + CountW'(1);
                        state_reg <= S_SORT_LD;
                    end else begin
                        state_reg <= (op_reg == OP_BSRCH) ? S_SRCH_RD : S_DONE;
                    end
                end
                S_SRCH_RD: state_reg <= S_SRCH_CMP;
                S_SRCH_CMP: begin
                    if (op_reg == OP_BSRCH) begin
                        if (rd_key_reg == key_reg) begin
                            fidx_reg <= mid[AddrW-1:0]; otag_reg <= rd_tag_reg;
                            state_reg <= S_DONE;
                        end else if (rd_key_reg < key_reg) begin
                            lo_reg <= mid + 8'sd1;
                            state_reg <= (mid + 8'sd1 <= hi_reg) ? S_SRCH_RD : S_DONE;
                            if (!(mid + 8'sd1 <= hi_reg)) st_reg <= ST_NOT_FOUND;
                        end else begin
                            hi_reg <= mid - 8'sd1;
                            state_reg <= (lo_reg <= mid - 8'sd1) ? S_SRCH_RD : S_DONE;
                            if (!(lo_reg <= mid - 8'sd1)) st_reg <= ST_NOT_FOUND;
                        end
                    end else if (rd_key_reg == key_reg) begin
                        fidx_reg <= i_reg[AddrW-1:0]; otag_reg <= rd_tag_reg;
                        if (op_reg == OP_DELETE) begin
                            count_reg <= count_reg - CountW'(1);
                            state_reg <= (i_reg + CountW'(1) < count_reg) ? S_DEL_RD : S_DONE;
                        end else begin
                            state_reg <= S_DONE;
                        end
                    end else if (i_reg + CountW'(1) < count_reg) begin
                        i_reg <= i_reg + CountW'(1);
                        state_reg <= S_SRCH_RD;
                    end else begin
                        st_reg <= ST_NOT_FOUND;
                        state_reg <= S_DONE;
                    end
                end
                S_DEL_RD: state_reg <= S_DEL_WR;
                // count_reg already holds the new count: stop at its last entry
                S_DEL_WR: begin
                    i_reg <= i_reg + CountW'(1);
                    state_reg <= (i_reg + CountW'(1) < count_reg) ? S_DEL_RD : S_DONE;
                end
                S_DONE: if (m_tready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CountW'(Depth)) else $error("entry count over depth");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata)) else $error("result changed");
    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> !we) else $error("write while idle");
`endif
endmodule
`default_nettype wire
